// File: src/frpa_pkg.sv
// Package with the shared types and constants of the free region page allocator.
package frpa_pkg;

	localparam int MAX_REGIONS = 32;
	localparam int MAX_PAGES   = 64;
	localparam int PAGE_SH     = 12;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int PG_W        = $clog2(MAX_PAGES + 1);

	localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SH;
	localparam logic [63:0] PAGE_MASK  = PAGE_BYTES - 64'd1;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_RSV = 2'd1;
	localparam logic [1:0] OP_MAP = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] len;
	} region_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_NEXT,
		CELL_PREV,
		CELL_EXT
	} cell_sel_t;

	typedef struct packed {
		region_t         rsv_reg;
		logic [63:0]     rsv_lost;
		logic            rsv_hit;
		logic            pend_vld;
		region_t         pend;
		region_t         aln_reg;
		logic [63:0]     aln_off;
		logic            aln_hit;
		logic [PG_W-1:0] aln_pages;
	} head_res_t;

endpackage

// File: src/free_region_page_allocator_core.sv
// Top level of the free region page allocator: control, ring of table cells and result register.
//
// Items arrive on in_valid/in_ready and results leave on out_valid/out_ready.
// The region table is a ring of 32 cells; a full pass rotates every entry once
// past the head unit, one entry per cycle, except that the second map pass
// holds the ring at each eligible page until its result is sent.
// Add inserts the region if the table has room and gives one result. Reserve
// takes one ring pass, then re-inserts each upper part in turn and finishes
// the insertion before giving its result.
// Map takes one ring pass for alignment, a set-up step, then a second pass
// in which each page result is sent from the head region, and a final result
// when pages run short or none were asked for.
// A new item is taken only once the previous one has delivered all results;
// the last result may still sit in the output register when it is taken.
// A stalled receiver holds the block at the next result to be sent.
// After reset the table is empty and the free byte count is zero; the table
// contents need no clearing.
module free_region_page_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] region_start,
	input  logic [63:0] region_end,
	input  logic [63:0] virtual_base,
	input  logic [6:0]  page_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [63:0] virtual_page,
	output logic [63:0] physical_page,
	output logic [63:0] free_total,
	output logic        last
);
	import frpa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ADD, S_RESP, S_RSV_SCAN, S_RSV_INS,
		S_MAP_ALIGN, S_MAP_PREP, S_MAP_EMIT, S_MAP_END
	} state_t;

	state_t state_q;

	logic [63:0]      s_q, e_q, vbase_q, free_q;
	logic [PG_W-1:0]  want_q, avail_q, got_q, got_tot_q;
	logic [IDX_W-1:0] t_q;
	logic [CNT_W-1:0] count_q, pend_cnt_q, pend_rd_q;
	logic [1:0]       status_q;
	region_t          pend_q [MAX_REGIONS];

	logic        out_valid_q, last_q;
	logic [1:0]  ostat_q;
	logic [63:0] vp_q, pp_q, ftot_q;

	region_t     cell_q [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] ge;
	cell_sel_t   sel [MAX_REGIONS];
	region_t     head, proc_out, ins_reg, emit_wb;
	head_res_t   hres;

	logic            can_push, active, t_end, ins_en, rotate, elig, emit_now, out_push;
	logic [CNT_W-1:0] ins_pos;
	logic [63:0]     add_len;
	logic [PG_W:0]   avail_sum;
	logic [PG_W-1:0] avail_nx, got_tot;

	assign head = cell_q[0];

	frpa_head u_head (
		.cur       (head),
		.rsv_start (s_q),
		.rsv_end   (e_q),
		.res       (hres)
	);

	always_comb begin
		can_push = !out_valid_q || out_ready;
		active   = CNT_W'(t_q) < count_q;
		t_end    = t_q == IDX_W'(MAX_REGIONS - 1);
		add_len  = (e_q > s_q) ? (e_q - s_q) : 64'd0;
		ins_en   = 1'b0;
		ins_reg  = '0;
		if (state_q == S_ADD) begin
			ins_en  = count_q < CNT_W'(MAX_REGIONS);
			ins_reg = '{base: s_q, len: add_len};
		end else if (state_q == S_RSV_INS) begin
			ins_en  = (pend_rd_q < pend_cnt_q) && (count_q < CNT_W'(MAX_REGIONS));
			ins_reg = pend_q[pend_rd_q[IDX_W-1:0]];
		end

		// Insert after the last entry whose base is not below the new one.
		ins_pos = '0;
		for (int k = 0; k < MAX_REGIONS; k++) begin
			if (ge[k] && (CNT_W'(k) < count_q))
				ins_pos = CNT_W'(k + 1);
		end

		elig     = active && (head.len >= PAGE_BYTES) && (got_q < got_tot_q);
		emit_now = (state_q == S_MAP_EMIT) && elig && can_push;
		out_push = emit_now || (can_push && ((state_q == S_RESP) ||
			((state_q == S_MAP_END) && (got_tot_q < want_q || want_q == '0))));
		rotate   = (state_q == S_RSV_SCAN) || (state_q == S_MAP_ALIGN) ||
			((state_q == S_MAP_EMIT) && !elig);
		emit_wb  = '{base: head.base + PAGE_BYTES, len: head.len - PAGE_BYTES};

		proc_out = head;
		if (state_q == S_RSV_SCAN && active && hres.rsv_hit)
			proc_out = hres.rsv_reg;
		else if (state_q == S_MAP_ALIGN && active && hres.aln_hit)
			proc_out = hres.aln_reg;

		for (int k = 0; k < MAX_REGIONS; k++) begin
			sel[k] = CELL_HOLD;
			if (rotate)
				sel[k] = CELL_NEXT;
			else if (ins_en) begin
				if (CNT_W'(k) == ins_pos)
					sel[k] = CELL_EXT;
				else if (CNT_W'(k) > ins_pos && CNT_W'(k) <= count_q)
					sel[k] = CELL_PREV;
			end else if (emit_now && k == 0)
				sel[k] = CELL_EXT;
		end

		avail_sum = {1'b0, avail_q} + {1'b0, hres.aln_pages};
		avail_nx  = (avail_sum > (PG_W + 1)'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : avail_sum[PG_W-1:0];
		got_tot   = (want_q < avail_q) ? want_q : avail_q;
	end

	for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
		region_t prev_d, next_d, ext_d;
		assign prev_d = (k == 0) ? region_t'('0) : cell_q[(k == 0) ? 0 : k - 1];
		assign next_d = (k == MAX_REGIONS - 1) ? proc_out :
			cell_q[(k == MAX_REGIONS - 1) ? k : k + 1];
		assign ext_d  = (k == 0 && state_q == S_MAP_EMIT) ? emit_wb : ins_reg;
		frpa_cell u_cell (
			.clk      (clk),
			.sel      (sel[k]),
			.prev     (prev_d),
			.next     (next_d),
			.ext      (ext_d),
			.cmp_base (ins_reg.base),
			.q        (cell_q[k]),
			.ge       (ge[k])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			s_q     <= region_start;
			e_q     <= region_end;
			vbase_q <= virtual_base & ~PAGE_MASK;
		end
		if (state_q == S_RSV_SCAN && active && hres.rsv_hit && hres.pend_vld)
			pend_q[pend_cnt_q[IDX_W-1:0]] <= hres.pend;
		if (out_ready || !out_valid_q) begin
			vp_q   <= emit_now ? (vbase_q + (64'(got_q) << PAGE_SH)) : 64'd0;
			pp_q   <= emit_now ? head.base : 64'd0;
			ftot_q <= free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			free_q      <= 64'd0;
			t_q         <= '0;
			want_q      <= '0;
			avail_q     <= '0;
			got_q       <= '0;
			got_tot_q   <= '0;
			pend_cnt_q  <= '0;
			pend_rd_q   <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
			ostat_q     <= ST_OK;
			last_q      <= 1'b0;
		end else begin
			if (out_push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (ins_en) begin
				count_q <= count_q + CNT_W'(1);
				free_q  <= free_q + ins_reg.len;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						status_q <= ST_OK;
						t_q      <= '0;
						avail_q  <= '0;
						want_q   <= (page_count > 7'(MAX_PAGES)) ? PG_W'(MAX_PAGES) :
							PG_W'(page_count);
						unique case (operation)
							OP_ADD: state_q <= S_ADD;
							OP_RSV: begin
								pend_cnt_q <= '0;
								state_q    <= (region_end > region_start) ? S_RSV_SCAN : S_RESP;
							end
							OP_MAP:  state_q <= S_MAP_ALIGN;
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_ADD: begin
					if (!ins_en)
						status_q <= ST_FULL;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (can_push) begin
						ostat_q <= status_q;
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RSV_SCAN: begin
					if (active && hres.rsv_hit) begin
						free_q <= free_q - hres.rsv_lost;
						if (hres.pend_vld)
							pend_cnt_q <= pend_cnt_q + CNT_W'(1);
					end
					t_q <= t_q + IDX_W'(1);
					if (t_end) begin
						pend_rd_q <= '0;
						state_q   <= S_RSV_INS;
					end
				end
				S_RSV_INS: begin
					if (pend_rd_q < pend_cnt_q) begin
						if (!ins_en)
							status_q <= ST_FULL;
						pend_rd_q <= pend_rd_q + CNT_W'(1);
					end else begin
						state_q <= S_RESP;
					end
				end
				S_MAP_ALIGN: begin
					if (active && hres.aln_hit) begin
						free_q  <= free_q - hres.aln_off;
						avail_q <= avail_nx;
					end
					t_q <= t_q + IDX_W'(1);
					if (t_end)
						state_q <= S_MAP_PREP;
				end
				S_MAP_PREP: begin
					// Every page that will be handed out is known now, so the final count is too.
					got_tot_q <= got_tot;
					got_q     <= '0;
					free_q    <= free_q - (64'(got_tot) << PAGE_SH);
					state_q   <= S_MAP_EMIT;
				end
				S_MAP_EMIT: begin
					if (emit_now) begin
						ostat_q <= ST_OK;
						last_q  <= ({1'b0, got_q} + (PG_W + 1)'(1)) == {1'b0, want_q};
						got_q   <= got_q + PG_W'(1);
					end else if (!elig) begin
						t_q <= t_q + IDX_W'(1);
						if (t_end)
							state_q <= S_MAP_END;
					end
				end
				S_MAP_END: begin
					if (got_tot_q < want_q || want_q == '0) begin
						if (can_push) begin
							ostat_q <= (want_q == '0) ? ST_OK : ST_OOM;
							last_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = state_q == S_IDLE;
	assign out_valid     = out_valid_q;
	assign status        = ostat_q;
	assign virtual_page  = vp_q;
	assign physical_page = pp_q;
	assign free_total    = ftot_q;
	assign last          = last_q;

endmodule

// File: src/frpa_cell.sv
// One table cell: holds a region and loads it from a neighbour or an external source.
module frpa_cell (
	input  logic               clk,
	input  frpa_pkg::cell_sel_t sel,
	input  frpa_pkg::region_t  prev,
	input  frpa_pkg::region_t  next,
	input  frpa_pkg::region_t  ext,
	input  logic [63:0]        cmp_base,
	output frpa_pkg::region_t  q,
	output logic               ge
);
	import frpa_pkg::*;

	region_t reg_q;

	always_ff @(posedge clk) begin
		unique case (sel)
			CELL_HOLD: reg_q <= reg_q;
			CELL_NEXT: reg_q <= next;
			CELL_PREV: reg_q <= prev;
			CELL_EXT:  reg_q <= ext;
			default:   reg_q <= reg_q;
		endcase
	end

	assign q  = reg_q;
	assign ge = reg_q.base >= cmp_base;

endmodule

// File: src/frpa_head.sv
// Arithmetic on the region at the head of the ring for reserve and page alignment.
module frpa_head (
	input  frpa_pkg::region_t   cur,
	input  logic [63:0]         rsv_start,
	input  logic [63:0]         rsv_end,
	output frpa_pkg::head_res_t res
);
	import frpa_pkg::*;

	logic [63:0] re;
	logic [63:0] off;
	logic [63:0] alen;
	logic [63:0] npages;

	always_comb begin
		re  = cur.base + cur.len;
		res = '0;
		res.rsv_hit = (cur.base < rsv_end) && (rsv_start < re);
		res.rsv_reg = cur;
		if (rsv_start <= cur.base && rsv_end >= re) begin
			res.rsv_reg.len = 64'd0;
			res.rsv_lost    = cur.len;
		end else if (rsv_start <= cur.base) begin
			res.rsv_reg.base = rsv_end;
			res.rsv_reg.len  = cur.len - (rsv_end - cur.base);
			res.rsv_lost     = rsv_end - cur.base;
		end else begin
			// The region is cut at the start of the interval; any upper part is re-inserted.
			res.rsv_reg.len = rsv_start - cur.base;
			res.rsv_lost    = re - rsv_start;
			res.pend_vld    = rsv_end < re;
			res.pend.base   = rsv_end;
			res.pend.len    = re - rsv_end;
		end

		off    = (64'd0 - cur.base) & PAGE_MASK;
		alen   = cur.len - off;
		npages = alen >> PAGE_SH;
		res.aln_hit      = cur.len >= PAGE_BYTES;
		res.aln_off      = off;
		res.aln_reg.base = cur.base + off;
		res.aln_reg.len  = alen;
		res.aln_pages    = (npages > 64'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : npages[PG_W-1:0];
	end

endmodule
